// ===== rtl/touch_pen_oversample_averager_assert.svh =====
// Assertion macros shared by the averager modules.
// TPOA_ASSERT checks a property outside reset; TPOA_ASSERT_RST also checks during reset.
`ifndef TOUCH_PEN_OVERSAMPLE_AVERAGER_ASSERT_SVH
`define TOUCH_PEN_OVERSAMPLE_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS
`define TPOA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpoa assertion failed");
`define TPOA_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tpoa assertion failed");
`else
`define TPOA_ASSERT(label, prop)
`define TPOA_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/tpoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpoa_pkg;

    localparam int MAX_SHIFT   = 6;
    localparam int SHIFT_W     = 3;
    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 7;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

    typedef enum logic [1:0] {
        MODE_PEN  = 2'd0,
        MODE_CONV = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REP_NONE    = 2'd0,
        REP_PRESS   = 2'd1,
        REP_RELEASE = 2'd2
    } t_report;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_CONVERT   = 2'd1,
        CMD_WAIT_DOWN = 2'd2,
        CMD_WAIT_UP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic                pen_down;
    } t_event;

    typedef struct packed {
        t_report             report;
        logic [SAMPLE_W-1:0] x_pos;
        logic [SAMPLE_W-1:0] y_pos;
        t_cmd                command;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/touch_pen_oversample_averager.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "touch_pen_oversample_averager_assert.svh"

// Touch pen averager: takes one event request per clock while o_stall is low and
// returns exactly one result request for each, through the input register, then
// one combinational pass of add, compare and shift into the result register.
// With no stall on the output the rate is one request per cycle; a stalled result
// still lets one more request enter the input register. Write the oversample
// shift only while no request is in flight; values above 6 act as 6.
module touch_pen_oversample_averager (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [tpoa_pkg::SHIFT_W-1:0]      i_cfg_wr_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [tpoa_pkg::SAMPLE_W-1:0]     i_x_sample,
    input  wire logic [tpoa_pkg::SAMPLE_W-1:0]     i_y_sample,
    input  wire logic                              i_x_pen_up,
    input  wire logic                              i_y_pen_up,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [1:0]                             o_report,
    output logic [tpoa_pkg::SAMPLE_W-1:0]          o_x_pos,
    output logic [tpoa_pkg::SAMPLE_W-1:0]          o_y_pos,
    output logic [1:0]                             o_command
);

    logic              r_in_valid;
    tpoa_pkg::t_event  r_event;
    logic              r_out_valid;
    tpoa_pkg::t_result r_result;
    tpoa_pkg::t_result result;
    logic              advance;
    logic              accept;
    logic              fire;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign fire    = r_in_valid && advance;

    tpoa_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_event       (r_event),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event.mode     <= i_mode;
            r_event.x_sample <= i_x_sample;
            r_event.y_sample <= i_y_sample;
            r_event.pen_down <= !(i_x_pen_up || i_y_pen_up);
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_report  = r_result.report;
    assign o_x_pos   = r_result.x_pos;
    assign o_y_pos   = r_result.y_pos;
    assign o_command = r_result.command;

    `TPOA_ASSERT(a_press_restarts, (o_valid && o_report == tpoa_pkg::REP_PRESS) |-> o_command == tpoa_pkg::CMD_CONVERT)
    `TPOA_ASSERT(a_fire_fills_out, fire |=> r_out_valid)
    `TPOA_ASSERT(a_skid_accepts, (r_out_valid && i_stall && !r_in_valid) |-> !o_stall)

endmodule

`default_nettype wire

// ===== rtl/tpoa_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "touch_pen_oversample_averager_assert.svh"

module tpoa_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [tpoa_pkg::SHIFT_W-1:0]     i_cfg_wr_data,
    input  wire logic                             i_fire,
    input  wire tpoa_pkg::t_event                 i_event,
    output tpoa_pkg::t_result                     o_result
);

    logic [tpoa_pkg::SHIFT_W-1:0]  r_shift;
    logic [tpoa_pkg::SUM_W-1:0]    r_x_sum;
    logic [tpoa_pkg::SUM_W-1:0]    r_y_sum;
    logic [tpoa_pkg::COUNT_W-1:0]  r_count;
    logic [tpoa_pkg::SUM_W-1:0]    n_x_sum;
    logic [tpoa_pkg::SUM_W-1:0]    n_y_sum;
    logic [tpoa_pkg::COUNT_W-1:0]  n_count;

    logic [tpoa_pkg::SHIFT_W-1:0]  eff_shift;
    logic [tpoa_pkg::SUM_W:0]      x_add;
    logic [tpoa_pkg::SUM_W:0]      y_add;
    logic [tpoa_pkg::SUM_W-1:0]    x_shr;
    logic [tpoa_pkg::SUM_W-1:0]    y_shr;
    logic [tpoa_pkg::COUNT_W:0]    limit;
    logic [tpoa_pkg::COUNT_W-1:0]  count_inc;
    logic                          tick_en;
    tpoa_pkg::t_result             res;

    assign eff_shift = (r_shift > tpoa_pkg::SHIFT_W'(tpoa_pkg::MAX_SHIFT))
                     ? tpoa_pkg::SHIFT_W'(tpoa_pkg::MAX_SHIFT) : r_shift;
    assign x_add = {1'b0, r_x_sum} + (tpoa_pkg::SUM_W+1)'(i_event.x_sample);
    assign y_add = {1'b0, r_y_sum} + (tpoa_pkg::SUM_W+1)'(i_event.y_sample);
    assign x_shr = r_x_sum >> eff_shift;
    assign y_shr = r_y_sum >> eff_shift;
    assign limit = (tpoa_pkg::COUNT_W+1)'(1) << eff_shift;
    assign count_inc = (&r_count) ? r_count : r_count + tpoa_pkg::COUNT_W'(1);

    always_comb begin
        n_x_sum        = r_x_sum;
        n_y_sum        = r_y_sum;
        n_count        = r_count;
        tick_en        = 1'b0;
        res.report     = tpoa_pkg::REP_NONE;
        res.x_pos      = '0;
        res.y_pos      = '0;
        res.command    = tpoa_pkg::CMD_NONE;
        unique case (i_event.mode)
            tpoa_pkg::MODE_PEN: begin
                tick_en = i_event.pen_down;
            end
            tpoa_pkg::MODE_CONV: begin
                n_x_sum = x_add[tpoa_pkg::SUM_W] ? '1 : x_add[tpoa_pkg::SUM_W-1:0];
                n_y_sum = y_add[tpoa_pkg::SUM_W] ? '1 : y_add[tpoa_pkg::SUM_W-1:0];
                n_count = count_inc;
                if ({1'b0, count_inc} < limit) begin
                    res.command = tpoa_pkg::CMD_CONVERT;
                end else begin
                    res.command = tpoa_pkg::CMD_WAIT_UP;
                end
            end
            tpoa_pkg::MODE_TICK: begin
                tick_en = 1'b1;
            end
            default: begin
            end
        endcase
        if (tick_en) begin
            if (i_event.pen_down) begin
                if (r_count != '0) begin
                    res.report = tpoa_pkg::REP_PRESS;
                    res.x_pos  = (|x_shr[tpoa_pkg::SUM_W-1:tpoa_pkg::SAMPLE_W])
                               ? '1 : x_shr[tpoa_pkg::SAMPLE_W-1:0];
                    res.y_pos  = (|y_shr[tpoa_pkg::SUM_W-1:tpoa_pkg::SAMPLE_W])
                               ? '1 : y_shr[tpoa_pkg::SAMPLE_W-1:0];
                end
                n_x_sum     = '0;
                n_y_sum     = '0;
                n_count     = '0;
                res.command = tpoa_pkg::CMD_CONVERT;
            end else begin
                n_count     = '0;
                res.report  = tpoa_pkg::REP_RELEASE;
                res.command = tpoa_pkg::CMD_WAIT_DOWN;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= tpoa_pkg::SHIFT_RESET;
            r_x_sum <= '0;
            r_y_sum <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_shift <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_x_sum <= n_x_sum;
                r_y_sum <= n_y_sum;
                r_count <= n_count;
            end
        end
    end

    `TPOA_ASSERT_RST(a_shift_reset, !i_rst_n |=> r_shift == tpoa_pkg::SHIFT_RESET)
    `TPOA_ASSERT(a_tick_clears_count, (i_fire && tick_en) |=> r_count == '0)
    `TPOA_ASSERT(a_conv_counts, (i_fire && i_event.mode == tpoa_pkg::MODE_CONV) |=> r_count != '0)

endmodule

`default_nettype wire

// ===== dv/touch_pen_oversample_averager_tb.sv =====
`timescale 1ns / 1ps

module touch_pen_oversample_averager_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned SUM_LIMIT   = 65535;
    localparam int unsigned COUNT_LIMIT = 127;
    localparam int unsigned POS_LIMIT   = 1023;
    localparam int unsigned PHASE_ITEMS = 55;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [1:0]                    mode;
        logic [tpoa_pkg::SAMPLE_W-1:0] x;
        logic [tpoa_pkg::SAMPLE_W-1:0] y;
        logic                          x_up;
        logic                          y_up;
    } t_touch_evt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [tpoa_pkg::SHIFT_W-1:0] i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_mode = '0;
    logic [tpoa_pkg::SAMPLE_W-1:0] i_x_sample = '0;
    logic [tpoa_pkg::SAMPLE_W-1:0] i_y_sample = '0;
    logic i_x_pen_up = 1'b0;
    logic i_y_pen_up = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_report;
    logic [tpoa_pkg::SAMPLE_W-1:0] o_x_pos;
    logic [tpoa_pkg::SAMPLE_W-1:0] o_y_pos;
    logic [1:0] o_command;

    t_touch_evt        sensor_evt_q[$];
    tpoa_pkg::t_result predicted_outcome_q[$];

    int unsigned avg_shift = 32'(tpoa_pkg::SHIFT_RESET);
    int unsigned x_acc = 0;
    int unsigned y_acc = 0;
    int unsigned n_samples = 0;

    int unsigned send_idle_pct = 20;
    int unsigned recv_stall_pct = 20;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    touch_pen_oversample_averager i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_x_sample   (i_x_sample),
        .i_y_sample   (i_y_sample),
        .i_x_pen_up   (i_x_pen_up),
        .i_y_pen_up   (i_y_pen_up),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_report     (o_report),
        .o_x_pos      (o_x_pos),
        .o_y_pos      (o_y_pos),
        .o_command    (o_command)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned eff_shift();
        return (avg_shift > tpoa_pkg::MAX_SHIFT) ? tpoa_pkg::MAX_SHIFT : avg_shift;
    endfunction

    function automatic logic [tpoa_pkg::SAMPLE_W-1:0] average_of(int unsigned acc);
        int unsigned v;
        v = acc >> eff_shift();
        return (v > POS_LIMIT) ? tpoa_pkg::SAMPLE_W'(POS_LIMIT) : tpoa_pkg::SAMPLE_W'(v);
    endfunction

    function automatic tpoa_pkg::t_result apply_touch_event(t_touch_evt ev);
        tpoa_pkg::t_result res;
        logic pen_down;
        int unsigned x_new;
        int unsigned y_new;
        res.report  = tpoa_pkg::REP_NONE;
        res.x_pos   = '0;
        res.y_pos   = '0;
        res.command = tpoa_pkg::CMD_NONE;
        pen_down = !ev.x_up && !ev.y_up;
        if (ev.mode == tpoa_pkg::MODE_CONV) begin
            x_new = x_acc + 32'(ev.x);
            y_new = y_acc + 32'(ev.y);
            x_acc = (x_new > SUM_LIMIT) ? SUM_LIMIT : x_new;
            y_acc = (y_new > SUM_LIMIT) ? SUM_LIMIT : y_new;
            n_samples = (n_samples >= COUNT_LIMIT) ? COUNT_LIMIT : n_samples + 1;
            res.command = (n_samples < (1 << eff_shift())) ? tpoa_pkg::CMD_CONVERT
                                                             : tpoa_pkg::CMD_WAIT_UP;
        end else if (ev.mode == tpoa_pkg::MODE_TICK ||
                     (ev.mode == tpoa_pkg::MODE_PEN && pen_down)) begin
            if (pen_down) begin
                if (n_samples != 0) begin
                    res.report = tpoa_pkg::REP_PRESS;
                    res.x_pos  = average_of(x_acc);
                    res.y_pos  = average_of(y_acc);
                end
                x_acc = 0;
                y_acc = 0;
                n_samples = 0;
                res.command = tpoa_pkg::CMD_CONVERT;
            end else begin
                n_samples = 0;
                res.report  = tpoa_pkg::REP_RELEASE;
                res.command = tpoa_pkg::CMD_WAIT_DOWN;
            end
        end
        return res;
    endfunction

    task automatic push_evt(logic [1:0] mode, int unsigned x, int unsigned y,
                            logic x_up, logic y_up);
        t_touch_evt ev;
        ev.mode = mode;
        ev.x    = tpoa_pkg::SAMPLE_W'(x);
        ev.y    = tpoa_pkg::SAMPLE_W'(y);
        ev.x_up = x_up;
        ev.y_up = y_up;
        sensor_evt_q.push_back(ev);
    endtask

    function automatic int unsigned rand_sample();
        return ($urandom_range(0, 5) == 0) ? POS_LIMIT : $urandom_range(0, POS_LIMIT);
    endfunction

    task automatic push_conversions(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            push_evt(tpoa_pkg::MODE_CONV, rand_sample(), rand_sample(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_random_phase(int unsigned items);
        int remaining;
        int unsigned roll;
        int unsigned burst;
        logic [1:0] m;
        logic xu;
        logic yu;
        remaining = items;
        while (remaining > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                m  = 2'($urandom_range(0, 3));
                xu = 1'($urandom_range(0, 1));
                yu = 1'($urandom_range(0, 1));
                push_evt(m, $urandom_range(0, POS_LIMIT), $urandom_range(0, POS_LIMIT), xu, yu);
                if (m == tpoa_pkg::MODE_CONV || m == tpoa_pkg::MODE_TICK ||
                    (m == tpoa_pkg::MODE_PEN && !xu && !yu))
                    remaining--;
            end else if (roll < 25) begin
                xu = 1'($urandom_range(0, 1));
                push_evt(tpoa_pkg::MODE_TICK, $urandom_range(0, POS_LIMIT),
                         $urandom_range(0, POS_LIMIT), xu, !xu | 1'($urandom_range(0, 1)));
                burst = $urandom_range(0, 3);
                push_conversions(burst);
                remaining -= burst + 1;
            end else begin
                push_evt($urandom_range(0, 1) ? tpoa_pkg::MODE_TICK : tpoa_pkg::MODE_PEN,
                         $urandom_range(0, POS_LIMIT), $urandom_range(0, POS_LIMIT), 1'b0, 1'b0);
                roll = $urandom_range(0, 9);
                if (roll < 8)
                    burst = 1 << eff_shift();
                else if (roll < 9)
                    burst = $urandom_range(1, (1 << eff_shift()) + 2);
                else
                    burst = $urandom_range(100, 140);
                push_conversions(burst);
                remaining -= burst + 1;
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (sensor_evt_q.size() != 0 || i_valid || predicted_outcome_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_shift(int unsigned value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tpoa_pkg::SHIFT_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        avg_shift = value;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_touch_evt ev;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                ev.mode = i_mode;
                ev.x    = i_x_sample;
                ev.y    = i_y_sample;
                ev.x_up = i_x_pen_up;
                ev.y_up = i_y_pen_up;
                predicted_outcome_q.push_back(apply_touch_event(ev));
            end
            if (!i_valid || !o_stall) begin
                if (sensor_evt_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    ev = sensor_evt_q.pop_front();
                    i_valid    <= 1'b1;
                    i_mode     <= ev.mode;
                    i_x_sample <= ev.x;
                    i_y_sample <= ev.y;
                    i_x_pen_up <= ev.x_up;
                    i_y_pen_up <= ev.y_up;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        tpoa_pkg::t_result want;
        if (o_valid && !i_stall) begin
            if (predicted_outcome_q.size() == 0) begin
                report_mismatch("unexpected result, report", int'(o_report),
                                int'(tpoa_pkg::REP_NONE));
            end else begin
                want = predicted_outcome_q.pop_front();
                if (o_report !== want.report)
                    report_mismatch("report", int'(o_report), int'(want.report));
                if (o_x_pos !== want.x_pos)
                    report_mismatch("x_pos", int'(o_x_pos), int'(want.x_pos));
                if (o_y_pos !== want.y_pos)
                    report_mismatch("y_pos", int'(o_y_pos), int'(want.y_pos));
                if (o_command !== want.command)
                    report_mismatch("command", int'(o_command), int'(want.command));
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("touch_pen_oversample_averager test failed");
            $finish;
        end
    end

    initial begin
        int unsigned shifts[8] = '{0, 6, 7, 3, 1, 5, 4, 2};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_evt(MODE_UNUSED, POS_LIMIT, POS_LIMIT, 1'b1, 1'b1);
        push_evt(tpoa_pkg::MODE_PEN, 0, 0, 1'b1, 1'b0);
        push_evt(tpoa_pkg::MODE_PEN, 0, 0, 1'b0, 1'b1);
        push_evt(tpoa_pkg::MODE_TICK, 0, 0, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, 0, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, 0, POS_LIMIT, 1'b1, 1'b1);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b1);
        push_evt(tpoa_pkg::MODE_CONV, 0, 0, 1'b1, 1'b0);
        push_evt(tpoa_pkg::MODE_PEN, 0, 0, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_TICK, 0, 0, 1'b1, 1'b1);
        push_conversions(0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_CONV, POS_LIMIT, POS_LIMIT, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_TICK, 0, 0, 1'b0, 1'b0);
        push_evt(tpoa_pkg::MODE_TICK, 0, 0, 1'b1, 1'b0);
        push_evt(tpoa_pkg::MODE_PEN, 0, 0, 1'b1, 1'b1);
        push_evt(MODE_UNUSED, 0, 0, 1'b0, 1'b0);

        foreach (shifts[p]) begin
            write_shift(shifts[p]);
            send_idle_pct  = (p == 3) ? 0 : 20;
            recv_stall_pct = (p == 3) ? 0 : 20;
            queue_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_outcome_q.size() == 0) begin
            $display("touch_pen_oversample_averager test passed");
        end else begin
            $display("touch_pen_oversample_averager test failed");
        end
        $finish;
    end

endmodule

// ===== touch_pen_oversample_averager.f =====
+incdir+rtl
rtl/tpoa_pkg.sv
rtl/tpoa_core.sv
rtl/touch_pen_oversample_averager.sv
dv/touch_pen_oversample_averager_tb.sv
